// File: sv/dssvf_pkg.sv
// Package for the double-sampled state-variable filter: widths, register
// indexes, sequencer states and fixed-point helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dssvf_pkg;

  // Sample format, Q1.(SAMPLE_W-1); valid range 12 to 32.
  localparam int SAMPLE_W   = 24;

  localparam int STATE_W    = 32;
  localparam int STATE_FRAC = 23;
  localparam int COEF_FRAC  = 16;

  localparam int FREQ_W     = 17;
  localparam int DAMP_W     = 18;
  localparam int DRIVE_W    = 17;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  // Multiplier operands and product; post-processing width.
  localparam int OP_W   = STATE_W + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int WIDE_W = PROD_W + 2;

  // Accumulator for band + freq*high, and pass sums.
  localparam int ACC_W  = STATE_W + 3;
  localparam int SUM_W  = STATE_W + 1;
  localparam int PSUM_W = STATE_W + 2;

  localparam logic [FREQ_W-1:0]  FREQ_RST  = FREQ_W'(16384);
  localparam logic [DAMP_W-1:0]  DAMP_RST  = '0;
  localparam logic [DRIVE_W-1:0] DRIVE_RST = DRIVE_W'(32768);

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = CFG_IDX_W'(2);

  // Input to Q9.23 and sum back to sample format.
  localparam int IN_LSH  = (SAMPLE_W <= 24) ? 24 - SAMPLE_W : 0;
  localparam int IN_RSH  = (SAMPLE_W > 24) ? SAMPLE_W - 24 : 0;
  localparam int OUT_RSH = (SAMPLE_W < 25) ? 25 - SAMPLE_W : 0;
  localparam int OUT_LSH = (SAMPLE_W > 25) ? SAMPLE_W - 25 : 0;

  localparam logic signed [WIDE_W-1:0] S32_MAX =
    {{(WIDE_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] S32_MIN = ~S32_MAX;
  localparam logic signed [WIDE_W-1:0] SMP_MAX =
    {{(WIDE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SMP_MIN = ~SMP_MAX;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DAMP,
    ST_MUL_FREQ_B,
    ST_MUL_SQ,
    ST_HIGH,
    ST_MUL_CUBE,
    ST_MUL_FREQ_H,
    ST_MUL_DRIVE,
    ST_BAND,
    ST_EMIT
  } state_t;

  // Arithmetic right shift, round half up.
  function automatic logic signed [WIDE_W-1:0] rnd_shr(
    input logic signed [WIDE_W-1:0] v,
    input int n
  );
    logic signed [WIDE_W-1:0] half;
    half = '0;
    if (n <= 0) begin
      return v;
    end
    half[n-1] = 1'b1;
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(
    input logic signed [WIDE_W-1:0] v
  );
    if (v > S32_MAX) begin
      return S32_MAX[STATE_W-1:0];
    end
    if (v < S32_MIN) begin
      return S32_MIN[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] to_state(
    input logic signed [SAMPLE_W-1:0] s
  );
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(s);
    w = rnd_shr(w, IN_RSH) <<< IN_LSH;
    return w[STATE_W-1:0];
  endfunction

  // Sum of two passes -> mean in sample format, saturated.
  function automatic logic signed [SAMPLE_W-1:0] emit(
    input logic signed [WIDE_W-1:0] sum
  );
    logic signed [WIDE_W-1:0] w;
    w = rnd_shr(sum, OUT_RSH) <<< OUT_LSH;
    if (w > SMP_MAX) begin
      w = SMP_MAX;
    end else if (w < SMP_MIN) begin
      w = SMP_MIN;
    end
    return w[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/double_sampled_state_variable_filter.sv
// Top level of the double-sampled state-variable filter: register port,
// sequencer and one shared multiplier. Depends on dssvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Double-sampled Chamberlin state-variable filter. Each input word (signed
// Q1.23 sample) runs two passes of the SVF update and yields one output
// word with the mean low, high, band, peak and notch values, saturated to
// the sample width. Coefficients (freq, damp, drive) come from software
// through the cfg port, which is always ready; write it only while the
// filter is idle. Each item runs from acceptance to the output register
// in 8 sequencer steps per pass, one per multiply or state update, plus
// the emit step that forms the outputs. The sample rate is set by the
// single 33x33 multiplier, which every product of a pass
// (damp*band, freq*band, band^2, band^3, freq*high, drive*cube) goes
// through in turn. A finished word waits in the output register; a new
// sample is taken as soon as the sequencer is back in idle.
module double_sampled_state_variable_filter
  import dssvf_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  // sample input
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [SAMPLE_W-1:0]  in_sample_in,
  // result output
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [SAMPLE_W-1:0] out_low_out,
  output logic signed [SAMPLE_W-1:0] out_high_out,
  output logic signed [SAMPLE_W-1:0] out_band_out,
  output logic signed [SAMPLE_W-1:0] out_peak_out,
  output logic signed [SAMPLE_W-1:0] out_notch_out,
  // coefficient registers
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [CFG_IDX_W-1:0]        cfg_index,
  input  wire [CFG_DATA_W-1:0]       cfg_data
);

  state_t state_r, state_nxt;

  logic [FREQ_W-1:0]  freq_r;
  logic [DAMP_W-1:0]  damp_r;
  logic [DRIVE_W-1:0] drive_r;

  // filter state and per-pass values
  logic signed [STATE_W-1:0] low_r, band_r;
  logic signed [STATE_W-1:0] x_r, notch_r, high_r, tmp_r, band0_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      pass_r;

  logic signed [SUM_W-1:0]   sum_low_r, sum_high_r, sum_notch_r;
  logic signed [PSUM_W-1:0]  sum_peak_r;

  // shared multiplier
  logic signed [OP_W-1:0]    op_a, op_b;
  logic signed [PROD_W-1:0]  prod, prod_r;
  logic signed [WIDE_W-1:0]  prod_w, r16, r23;

  logic signed [WIDE_W-1:0]  band_w, peak_w;
  logic signed [STATE_W-1:0] band_new;
  logic                      in_take, out_load;

  logic                      out_valid_r;
  logic signed [SAMPLE_W-1:0] low_o_r, high_o_r, band_o_r, peak_o_r, notch_o_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  assign out_valid     = out_valid_r;
  assign out_low_out   = low_o_r;
  assign out_high_out  = high_o_r;
  assign out_band_out  = band_o_r;
  assign out_peak_out  = peak_o_r;
  assign out_notch_out = notch_o_r;

  // operand select per step; coefficients are unsigned, so zero-extend
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_MUL_DAMP: begin
        op_a = $signed({{(OP_W-DAMP_W){1'b0}}, damp_r});
        op_b = OP_W'(band_r);
      end
      ST_MUL_FREQ_B: begin
        op_a = $signed({{(OP_W-FREQ_W){1'b0}}, freq_r});
        op_b = OP_W'(band_r);
      end
      ST_MUL_SQ: begin
        op_a = OP_W'(band_r);
        op_b = OP_W'(band_r);
      end
      ST_MUL_CUBE: begin
        op_a = OP_W'(tmp_r);
        op_b = OP_W'(band_r);
      end
      ST_MUL_FREQ_H: begin
        op_a = $signed({{(OP_W-FREQ_W){1'b0}}, freq_r});
        op_b = OP_W'(high_r);
      end
      ST_MUL_DRIVE: begin
        op_a = $signed({{(OP_W-DRIVE_W){1'b0}}, drive_r});
        op_b = OP_W'(tmp_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod   = op_a * op_b;
  assign prod_w = WIDE_W'(prod_r);
  assign r16    = rnd_shr(prod_w, COEF_FRAC);
  assign r23    = rnd_shr(prod_w, STATE_FRAC);

  // band = freq*high + band_old - drive*cube
  assign band_w   = WIDE_W'(acc_r) - r16;
  assign band_new = sat32(band_w);
  assign peak_w   = WIDE_W'(low_r) - WIDE_W'(high_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_take) state_nxt = ST_MUL_DAMP;
      ST_MUL_DAMP:   state_nxt = ST_MUL_FREQ_B;
      ST_MUL_FREQ_B: state_nxt = ST_MUL_SQ;
      ST_MUL_SQ:     state_nxt = ST_HIGH;
      ST_HIGH:       state_nxt = ST_MUL_CUBE;
      ST_MUL_CUBE:   state_nxt = ST_MUL_FREQ_H;
      ST_MUL_FREQ_H: state_nxt = ST_MUL_DRIVE;
      ST_MUL_DRIVE:  state_nxt = ST_BAND;
      ST_BAND:       state_nxt = pass_r ? ST_EMIT : ST_MUL_DAMP;
      ST_EMIT:       if (out_load) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // coefficient registers; unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_RST;
      damp_r  <= DAMP_RST;
      drive_r <= DRIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FREQ) begin
        freq_r <= cfg_data[FREQ_W-1:0];
      end else if (cfg_index == CFG_DAMP) begin
        damp_r <= cfg_data[DAMP_W-1:0];
      end else if (cfg_index == CFG_DRIVE) begin
        drive_r <= cfg_data[DRIVE_W-1:0];
      end
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      band_r <= '0;
    end else begin
      if (state_r == ST_MUL_SQ) begin
        low_r <= sat32(WIDE_W'(low_r) + r16);
      end
      if (state_r == ST_BAND) begin
        band_r <= band_new;
      end
    end
  end

  // pass datapath, no reset needed
  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          x_r    <= to_state(in_sample_in);
          pass_r <= 1'b0;
        end
      end
      ST_MUL_FREQ_B: notch_r <= sat32(WIDE_W'(x_r) - r16);
      ST_HIGH: begin
        high_r <= sat32(WIDE_W'(notch_r) - WIDE_W'(low_r));
        tmp_r  <= sat32(r23);   // band^2
      end
      ST_MUL_FREQ_H: tmp_r <= sat32(r23);   // band^3
      ST_MUL_DRIVE: begin
        acc_r <= ACC_W'(WIDE_W'(band_r) + r16);
      end
      ST_BAND: begin
        pass_r <= ~pass_r;
        if (!pass_r) begin
          band0_r     <= band_new;
          sum_low_r   <= SUM_W'(low_r);
          sum_high_r  <= SUM_W'(high_r);
          sum_notch_r <= SUM_W'(notch_r);
          sum_peak_r  <= peak_w[PSUM_W-1:0];
        end else begin
          sum_low_r   <= sum_low_r + SUM_W'(low_r);
          sum_high_r  <= sum_high_r + SUM_W'(high_r);
          sum_notch_r <= sum_notch_r + SUM_W'(notch_r);
          sum_peak_r  <= sum_peak_r + peak_w[PSUM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      low_o_r   <= emit(WIDE_W'(sum_low_r));
      high_o_r  <= emit(WIDE_W'(sum_high_r));
      band_o_r  <= emit(WIDE_W'(band0_r) + WIDE_W'(band_r));
      peak_o_r  <= emit(WIDE_W'(sum_peak_r));
      notch_o_r <= emit(WIDE_W'(sum_notch_r));
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for double_sampled_state_variable_filter: a queued
// driver, a checking monitor and a bit-exact software filter for prediction.
// Depends on dssvf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;
  import dssvf_pkg::*;

  // Run control
  localparam int LIMIT_CYCLES  = 400000;  // far above the slowest correct run
  localparam int SETTLE_CYCLES = 30;      // idle time before a register write
  localparam int DRAIN_CYCLES  = 40;      // quiet time after the last word
  localparam int LONG_HOLD     = 300;     // long output back-pressure stretch
  localparam int HOLD_AT_A     = 300;
  localparam int HOLD_AT_B     = 1100;
  localparam int MAX_GAP       = 13;
  localparam int RAND_PHASES   = 14;
  localparam int PHASE_WORDS   = 120;

  // Coefficient ranges
  localparam logic [CFG_DATA_W-1:0] FREQ_TOP  = CFG_DATA_W'(92682);
  localparam logic [CFG_DATA_W-1:0] DAMP_TOP  = CFG_DATA_W'(131072);
  localparam logic [CFG_DATA_W-1:0] DRIVE_TOP = CFG_DATA_W'(65536);
  localparam logic [CFG_DATA_W-1:0] ALL_ONES  = '1;
  // No register lives at this index; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0]  CFG_NONE  = CFG_IDX_W'(3);

  // Sample extremes
  localparam logic [SAMPLE_W-1:0] SMP_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SMP_ONE    = SAMPLE_W'(1);
  localparam logic [SAMPLE_W-1:0] SMP_MONE   = '1;
  localparam logic [SAMPLE_W-1:0] SMP_ZERO   = '0;

  // Format shifts: sample -> Q9.23 state, and pass sum -> sample.
  localparam int IN_UP    = (SAMPLE_W <= 24) ? 24 - SAMPLE_W : 0;
  localparam int IN_DOWN  = (SAMPLE_W > 24) ? SAMPLE_W - 24 : 0;
  localparam int OUT_DOWN = (SAMPLE_W < 25) ? 25 - SAMPLE_W : 0;
  localparam int OUT_UP   = (SAMPLE_W > 25) ? SAMPLE_W - 25 : 0;

  typedef enum logic {OP_SAMPLE, OP_REG_WRITE} op_kind_t;

  // One queued driver operation: a sample word or a coefficient write.
  typedef struct {
    op_kind_t               kind;
    logic [SAMPLE_W-1:0]    smp;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    int                     gap;
  } filter_op_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lp;
    logic [SAMPLE_W-1:0] hp;
    logic [SAMPLE_W-1:0] bp;
    logic [SAMPLE_W-1:0] pk;
    logic [SAMPLE_W-1:0] nt;
  } svf_word_t;

  // DUT ports; every input is known from time zero.
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample_in  = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [SAMPLE_W-1:0]   out_low_out;
  logic [SAMPLE_W-1:0]   out_high_out;
  logic [SAMPLE_W-1:0]   out_band_out;
  logic [SAMPLE_W-1:0]   out_peak_out;
  logic [SAMPLE_W-1:0]   out_notch_out;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Bench state
  filter_op_t pending_ops[$];
  svf_word_t  expected_outputs[$];
  int         samples_sent    = 0;   // driver only
  int         results_checked = 0;   // monitor only, updated with <=
  int         errors          = 0;
  int         gap_left        = 0;
  int         settle_left     = SETTLE_CYCLES;
  int         hold_left       = 0;
  logic       rx_gaps         = 1'b1;
  int         cycle_cnt       = 0;

  // Shadow copy of the filter: coefficients and the two Q9.23 states.
  logic [FREQ_W-1:0]  freq_c  = FREQ_RST;
  logic [DAMP_W-1:0]  damp_c  = DAMP_RST;
  logic [DRIVE_W-1:0] drive_c = DRIVE_RST;
  longint             lp_state = 0;
  longint             bp_state = 0;

  double_sampled_state_variable_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_low_out  (out_low_out),
    .out_high_out (out_high_out),
    .out_band_out (out_band_out),
    .out_peak_out (out_peak_out),
    .out_notch_out(out_notch_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Filter arithmetic, all in 64-bit signed integers
  // ---------------------------------------------------------------------

  // Arithmetic right shift rounding half up; >>> on longint floors.
  function automatic longint shr_round(input longint v, input int n);
    if (n <= 0) begin
      return v;
    end
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Q2.16 / Q1.16 coefficient times state value
  function automatic longint coef_scale(input longint c, input longint v);
    return shr_round(c * v, COEF_FRAC);
  endfunction

  // band^3 with a rounded, saturated square in between
  function automatic longint band_cubed(input longint b);
    longint sq;
    sq = clip(shr_round(b * b, STATE_FRAC), STATE_W);
    return clip(shr_round(sq * b, STATE_FRAC), STATE_W);
  endfunction

  // Sum of two passes -> mean in sample format, saturated
  function automatic logic [SAMPLE_W-1:0] to_sample(input longint sum);
    return SAMPLE_W'(clip(shr_round(sum <<< OUT_UP, OUT_DOWN), SAMPLE_W));
  endfunction

  // Two SVF passes per sample; pushes the expected output word.
  task automatic run_filter(input logic [SAMPLE_W-1:0] smp);
    longint    x;
    longint    b0;
    longint    nt;
    longint    hp;
    longint    s_lp;
    longint    s_hp;
    longint    s_bp;
    longint    s_pk;
    longint    s_nt;
    svf_word_t w;
    s_lp = 0;
    s_hp = 0;
    s_bp = 0;
    s_pk = 0;
    s_nt = 0;
    x = shr_round(longint'($signed(smp)) <<< IN_UP, IN_DOWN);
    for (int p = 0; p < 2; p++) begin
      b0       = bp_state;               // band from before the pass
      nt       = clip(x - coef_scale(damp_c, b0), STATE_W);
      lp_state = clip(lp_state + coef_scale(freq_c, b0), STATE_W);
      hp       = clip(nt - lp_state, STATE_W);
      bp_state = clip(coef_scale(freq_c, hp) + b0
                      - coef_scale(drive_c, band_cubed(b0)), STATE_W);
      s_lp += lp_state;
      s_hp += hp;
      s_bp += bp_state;
      s_pk += lp_state - hp;             // peak is not saturated per pass
      s_nt += nt;
    end
    w.lp = to_sample(s_lp);
    w.hp = to_sample(s_hp);
    w.bp = to_sample(s_bp);
    w.pk = to_sample(s_pk);
    w.nt = to_sample(s_nt);
    expected_outputs.push_back(w);
  endtask

  // Register write as the block sees it; upper data bits are dropped.
  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FREQ: begin
        freq_c = data[FREQ_W-1:0];
      end
      CFG_DAMP: begin
        damp_c = data[DAMP_W-1:0];
      end
      CFG_DRIVE: begin
        drive_c = data[DRIVE_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, $signed(want), $signed(got));
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------

  task automatic add_sample(input logic [SAMPLE_W-1:0] smp, input bit gaps_on);
    filter_op_t op;
    op.kind = OP_SAMPLE;
    op.smp  = smp;
    op.idx  = '0;
    op.data = '0;
    op.gap  = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    pending_ops.push_back(op);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    filter_op_t op;
    op.kind = OP_REG_WRITE;
    op.smp  = '0;
    op.idx  = idx;
    op.data = data;
    op.gap  = 0;
    pending_ops.push_back(op);
  endtask

  // Mix of full-scale noise, low-level signal and rail values.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0:       return SMP_TOP;
          1:       return SMP_BOTTOM;
          default: return SMP_ZERO;
        endcase
      end
      1, 2, 3, 4: begin
        return r[SAMPLE_W-1:0];
      end
      default: begin
        return $signed(r[SAMPLE_W-1:0]) >>> $urandom_range(4, SAMPLE_W - 4);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: feeds samples and register writes from pending_ops.
  // Register writes only go out once every expected word has been checked
  // and the block has sat idle for SETTLE_CYCLES.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic       nxt_in_valid;
    logic       nxt_cfg_valid;
    filter_op_t head;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      cfg_valid   <= 1'b0;
      gap_left    <= 0;
      settle_left <= SETTLE_CYCLES;
    end else begin
      nxt_in_valid  = in_valid;
      nxt_cfg_valid = cfg_valid;
      if (in_valid && !in_stall) begin
        run_filter(in_sample_in);
        samples_sent++;
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid && pending_ops.size() > 0) begin
        head = pending_ops[0];
        if (head.kind == OP_REG_WRITE) begin
          // sender pauses here until the filter has drained
          if (results_checked < samples_sent) begin
            settle_left <= SETTLE_CYCLES;
          end else if (settle_left > 0) begin
            settle_left <= settle_left - 1;
          end else begin
            cfg_index     <= head.idx;
            cfg_data      <= head.data;
            nxt_cfg_valid = 1'b1;
            void'(pending_ops.pop_front());
          end
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          in_sample_in <= head.smp;
          nxt_in_valid = 1'b1;
          void'(pending_ops.pop_front());
          // idle time before the next word starts once this one is taken
          if (pending_ops.size() > 0) begin
            gap_left <= pending_ops[0].gap;
          end
        end
      end
      in_valid  <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each output word against the oldest expectation and
  // draws a random stall after each word in stalling stretches. Twice in
  // the run it holds a LONG_HOLD stall so the filter backs up into its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int        hold_n;
    svf_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      hold_n = hold_left;
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("low_out", want.lp, out_low_out);
          check_field("high_out", want.hp, out_high_out);
          check_field("band_out", want.bp, out_band_out);
          check_field("peak_out", want.pk, out_peak_out);
          check_field("notch_out", want.nt, out_notch_out);
        end
        results_checked <= results_checked + 1;
        if (results_checked + 1 == HOLD_AT_A || results_checked + 1 == HOLD_AT_B) begin
          hold_n = LONG_HOLD;
        end else if (rx_gaps) begin
          hold_n = $urandom_range(0, MAX_GAP);
        end else begin
          hold_n = 0;
        end
        // switch between stalling and free-running stretches
        if ((results_checked + 1) % 64 == 0) begin
          rx_gaps <= ($urandom_range(0, 3) != 0);
        end
      end else if (hold_n > 0) begin
        hold_n--;
      end
      hold_left <= hold_n;
      out_stall <= (hold_n != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] f;
    logic [CFG_DATA_W-1:0] d;
    logic [CFG_DATA_W-1:0] r;
    bit                    gaps_on;

    // Directed, reset coefficients: zero, unit steps, rails, bit patterns.
    add_sample(SMP_ZERO, 1'b1);
    add_sample(SMP_ONE, 1'b1);
    add_sample(SMP_MONE, 1'b1);
    add_sample(SMP_TOP, 1'b0);
    add_sample(SMP_TOP, 1'b0);
    add_sample(SMP_BOTTOM, 1'b0);
    add_sample(SMP_BOTTOM, 1'b1);
    add_sample(SMP_TOP, 1'b1);
    add_sample({(SAMPLE_W/2){2'b01}}, 1'b1);
    add_sample({(SAMPLE_W/2){2'b10}}, 1'b1);

    // Top of every coefficient range, driven rail to rail: state saturation.
    add_cfg(CFG_FREQ, FREQ_TOP);
    add_cfg(CFG_DAMP, DAMP_TOP);
    add_cfg(CFG_DRIVE, DRIVE_TOP);
    repeat (3) add_sample(SMP_TOP, 1'b0);
    repeat (3) add_sample(SMP_BOTTOM, 1'b1);

    // All register bits set: out-of-range coefficients, dropped upper bits.
    add_cfg(CFG_FREQ, ALL_ONES);
    add_cfg(CFG_DAMP, ALL_ONES);
    add_cfg(CFG_DRIVE, ALL_ONES);
    add_sample(SMP_TOP, 1'b1);
    add_sample(SMP_BOTTOM, 1'b1);
    add_sample(SMP_ZERO, 1'b0);
    add_sample(SMP_TOP, 1'b0);
    add_sample(SMP_BOTTOM, 1'b1);

    // Zero coefficients; a write to the unused index must change nothing.
    add_cfg(CFG_FREQ, '0);
    add_cfg(CFG_DAMP, '0);
    add_cfg(CFG_DRIVE, '0);
    add_cfg(CFG_NONE, ALL_ONES);
    add_sample(SMP_TOP, 1'b1);
    add_sample(SMP_BOTTOM, 1'b1);
    add_sample(SMP_ONE, 1'b0);
    add_sample(SMP_MONE, 1'b1);

    // Random phases, each with a fresh coefficient set.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph % 4 == 0) begin
        // corners of the coefficient space
        f = $urandom_range(0, 1) ? FREQ_TOP : '0;
        d = $urandom_range(0, 1) ? DAMP_TOP : '0;
        r = $urandom_range(0, 1) ? DRIVE_TOP : '0;
      end else if (ph % 7 == 3) begin
        // raw register bits, range ignored
        f = CFG_DATA_W'($urandom);
        d = CFG_DATA_W'($urandom);
        r = CFG_DATA_W'($urandom);
      end else begin
        f = CFG_DATA_W'($urandom_range(0, int'(FREQ_TOP)));
        d = CFG_DATA_W'($urandom_range(0, int'(DAMP_TOP)));
        r = CFG_DATA_W'($urandom_range(0, int'(DRIVE_TOP)));
      end
      add_cfg(CFG_FREQ, f);
      add_cfg(CFG_DAMP, d);
      add_cfg(CFG_DRIVE, r);
      if ($urandom_range(0, 3) == 0) begin
        add_cfg(CFG_NONE, CFG_DATA_W'($urandom));
      end
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        add_sample(pick_sample(), gaps_on);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the queue to empty and every word to come back.
    while (!(pending_ops.size() == 0 && !in_valid && !cfg_valid
             && results_checked >= samples_sent)) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_outputs.size() != 0) begin
      $error("%0d expected output words never arrived", expected_outputs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
